### hw/rtl/orbr_pkg.sv
package orbr_pkg;

    localparam int CFG_W         = 13;
    localparam int SIZE_AT_RESET = 3000;

    typedef enum logic [1:0] {
        KIND_APPEND = 2'd0,
        KIND_REWIND = 2'd1,
        KIND_READ   = 2'd2,
        KIND_MOVE   = 2'd3
    } t_kind;

    typedef logic [CFG_W-1:0] t_size;

    typedef struct packed {
        t_kind              kind;
        logic signed [31:0] in_x;
        logic signed [31:0] in_y;
        logic               x_invalid;
        logic        [2:0]  reader;
        logic signed [15:0] offset;
    } t_req;

    typedef struct packed {
        logic               ok;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic               at_end;
        logic               expired_flag;
        logic               restarted_flag;
    } t_rsp;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
    } t_point;

endpackage

### hw/rtl/orbr_chan_if.sv
interface orbr_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/overwrite_ring_buffer_with_readers.sv
// Ring buffer of (x, y) points, 16.16 fixed point, with a set of reader cursors.
// i_req (sink) takes one request per cycle: append, rewind, read next or move.
// o_rsp (source) returns exactly one response per request, in request order.
// i_cfg (sink) writes the number of slots in use; it is always ready and empties
// the buffer. Write it only while no request is outstanding.
// Path: a taken request is held beside the point store's registered read port,
// and an output register follows before the response appears on o_rsp.
// Throughput: one request per cycle, sustained while o_rsp is ready.
// If o_rsp stalls, one further request is still taken and held behind the
// waiting response; i_req.ready then drops until o_rsp.ready returns.
// Reset (synchronous, active low) sets 3000 slots in use, an empty buffer, all
// cursors invalid and at end, and drops any response in flight. The point
// store is not cleared; slots are only read after they have been written.
module overwrite_ring_buffer_with_readers #(
    parameter int DEPTH   = 4096,
    parameter int READERS = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    orbr_chan_if.sink    i_req,
    orbr_chan_if.source  o_rsp,
    orbr_chan_if.sink    i_cfg
);

    localparam int IW         = $clog2(DEPTH + 1);
    localparam int IW1        = IW + 1;
    localparam int AW         = $clog2(DEPTH);
    localparam int RW         = (READERS > 1) ? $clog2(READERS) : 1;
    localparam int XW         = (RW > 3) ? RW : 3;
    localparam int SW         = (IW > orbr_pkg::CFG_W) ? IW : orbr_pkg::CFG_W;
    localparam int MW         = ((IW + 2 > 17) ? IW + 2 : 17) + 1;
    localparam int RESET_SIZE =
        (orbr_pkg::SIZE_AT_RESET > DEPTH) ? DEPTH : orbr_pkg::SIZE_AT_RESET;

    typedef struct packed {
        logic ok;
        logic read_hit;
        logic at_end;
        logic expired;
        logic restarted;
    } t_s1;

    function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] i,
                                                input logic [IW-1:0] n);
        logic [IW:0] s;
        s = {1'b0, i} + IW1'(1);
        return (s >= {1'b0, n}) ? '0 : s[IW-1:0];
    endfunction

    logic [IW-1:0]      r_size, n_size;
    logic [IW-1:0]      r_old, n_old;
    logic [IW-1:0]      r_wr, n_wr;
    logic signed [31:0] r_prev_x, n_prev_x;
    logic [IW-1:0]      r_cur [READERS];
    logic [IW-1:0]      n_cur [READERS];
    logic [READERS-1:0] r_restart, n_restart;
    logic [READERS-1:0] r_expire, n_expire;
    logic [READERS-1:0] r_end, n_end;

    logic               r_s1_valid;
    t_s1                r_s1, n_s1;
    logic               r_out_valid;
    orbr_pkg::t_rsp     r_out;

    orbr_pkg::t_req     req;
    logic               req_fire;
    logic               cfg_fire;
    logic               s1_adv;
    logic               is_empty;
    logic [XW-1:0]      rd_ext;
    logic [RW-1:0]      rd_idx;
    logic               rd_ok;
    logic [IW-1:0]      cfg_size;
    logic [SW-1:0]      cfg_ext;

    logic               mem_we;
    logic [AW-1:0]      mem_wa;
    orbr_pkg::t_point   mem_wp;
    logic               mem_re;
    logic [AW-1:0]      mem_ra;
    orbr_pkg::t_point   mem_rp;

    assign req      = i_req.payload;
    assign req_fire = i_req.valid && i_req.ready;
    assign cfg_fire = i_cfg.valid && i_cfg.ready;
    assign s1_adv   = r_s1_valid && (!r_out_valid || o_rsp.ready);

    assign i_req.ready = !r_s1_valid || !r_out_valid || o_rsp.ready;
    assign i_cfg.ready = 1'b1;
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

    assign is_empty = r_wr >= r_size;
    assign rd_ext   = XW'(req.reader);
    assign rd_idx   = rd_ext[RW-1:0];
    assign rd_ok    = 32'(req.reader) < 32'(READERS);

    always_comb begin
        cfg_ext = SW'(i_cfg.payload);
        if (cfg_ext == '0) begin
            cfg_ext = SW'(1);
        end else if (cfg_ext > SW'(DEPTH)) begin
            cfg_ext = SW'(DEPTH);
        end
        cfg_size = cfg_ext[IW-1:0];
    end

    assign mem_wp = '{x: req.in_x, y: req.in_y};

    always_comb begin
        logic                 flush;
        logic [IW-1:0]        w0, o0, w1, o1, c, idx, nx;
        logic signed [MW-1:0] lf, ll, ix, nm, off;

        n_size    = r_size;
        n_old     = r_old;
        n_wr      = r_wr;
        n_prev_x  = r_prev_x;
        n_cur     = r_cur;
        n_restart = r_restart;
        n_expire  = r_expire;
        n_end     = r_end;
        n_s1      = '0;
        mem_we    = 1'b0;
        mem_wa    = '0;
        mem_re    = 1'b0;
        mem_ra    = '0;
        flush     = 1'b0;
        w0 = '0; o0 = '0; w1 = '0; o1 = '0; c = '0; idx = '0; nx = '0;
        lf = '0; ll = '0; ix = '0; nm = '0; off = '0;

        if (cfg_fire) begin
            n_size = cfg_size;
            n_old  = cfg_size;
            n_wr   = cfg_size;
            for (int r = 0; r < READERS; r++) begin
                n_cur[r]     = cfg_size;
                n_restart[r] = 1'b1;
            end
        end else if (req_fire) begin
            unique case (req.kind)
                orbr_pkg::KIND_APPEND: begin
                    flush   = req.x_invalid || (!is_empty && (r_prev_x >= req.in_x));
                    n_s1.ok = 1'b1;
                    if (flush) begin
                        n_old = r_size;
                        n_wr  = r_size;
                        for (int r = 0; r < READERS; r++) begin
                            n_cur[r]     = r_size;
                            n_restart[r] = 1'b1;
                        end
                    end
                    if (!req.x_invalid) begin
                        w0       = (flush || is_empty) ? '0 : r_wr;
                        o0       = (flush || is_empty) ? '0 : r_old;
                        mem_we   = 1'b1;
                        mem_wa   = w0[AW-1:0];
                        n_prev_x = req.in_x;
                        w1       = next_slot(w0, r_size);
                        o1       = (w1 == o0) ? next_slot(o0, r_size) : o0;
                        n_wr     = w1;
                        n_old    = o1;
                        for (int r = 0; r < READERS; r++) begin
                            c        = flush ? r_size : r_cur[r];
                            n_end[r] = 1'b0;
                            if (c == w1) begin
                                n_expire[r] = 1'b1;
                                n_cur[r]    = o1;
                            end else if (c >= r_size) begin
                                n_cur[r] = o1;
                            end else begin
                                n_cur[r] = c;
                            end
                        end
                    end
                end
                orbr_pkg::KIND_REWIND: begin
                    if (rd_ok) begin
                        if (is_empty) begin
                            n_cur[rd_idx] = r_size;
                            n_end[rd_idx] = 1'b1;
                        end else begin
                            n_cur[rd_idx] = r_old;
                            n_end[rd_idx] = 1'b0;
                            n_s1.ok       = 1'b1;
                        end
                        n_restart[rd_idx] = 1'b0;
                        n_expire[rd_idx]  = 1'b0;
                    end
                end
                orbr_pkg::KIND_READ: begin
                    if (rd_ok) begin
                        idx = r_cur[rd_idx];
                        if (!is_empty && (idx != r_wr) && (idx < r_size)) begin
                            mem_re        = 1'b1;
                            mem_ra        = idx[AW-1:0];
                            nx            = next_slot(idx, r_size);
                            n_cur[rd_idx] = nx;
                            if (nx == r_wr) begin
                                n_end[rd_idx] = 1'b1;
                            end
                            n_s1.ok       = 1'b1;
                            n_s1.read_hit = 1'b1;
                        end
                    end
                end
                orbr_pkg::KIND_MOVE: begin
                    if (rd_ok) begin
                        if (is_empty) begin
                            n_end[rd_idx] = 1'b1;
                        end else begin
                            lf  = MW'(r_old);
                            ll  = MW'(r_wr);
                            ix  = MW'(r_cur[rd_idx]);
                            nm  = MW'(r_size);
                            off = MW'(req.offset);
                            if (ll < lf) begin
                                ll = ll + nm;
                                if (ix < lf) begin
                                    ix = ix + nm;
                                end
                            end
                            if (off >= ll - ix) begin
                                ix            = ll;
                                n_end[rd_idx] = 1'b1;
                            end else if (off <= lf - ix) begin
                                ix            = lf;
                                n_end[rd_idx] = 1'b0;
                            end else begin
                                ix            = ix + off;
                                n_end[rd_idx] = 1'b0;
                            end
                            if (ix >= nm) begin
                                ix = ix - nm;
                            end
                            n_cur[rd_idx] = ix[IW-1:0];
                        end
                    end
                end
            endcase
        end

        n_s1.at_end    = rd_ok && n_end[rd_idx];
        n_s1.expired   = rd_ok && n_expire[rd_idx];
        n_s1.restarted = rd_ok && n_restart[rd_idx];
    end

    orbr_point_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .i_clk      (i_clk),
        .i_wr_en    (mem_we),
        .i_wr_addr  (mem_wa),
        .i_wr_point (mem_wp),
        .i_rd_en    (mem_re),
        .i_rd_addr  (mem_ra),
        .o_rd_point (mem_rp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size      <= IW'(RESET_SIZE);
            r_old       <= IW'(RESET_SIZE);
            r_wr        <= IW'(RESET_SIZE);
            r_prev_x    <= '0;
            r_restart   <= '0;
            r_expire    <= '0;
            r_end       <= '1;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int r = 0; r < READERS; r++) begin
                r_cur[r] <= IW'(RESET_SIZE);
            end
        end else begin
            r_size    <= n_size;
            r_old     <= n_old;
            r_wr      <= n_wr;
            r_prev_x  <= n_prev_x;
            r_cur     <= n_cur;
            r_restart <= n_restart;
            r_expire  <= n_expire;
            r_end     <= n_end;
            if (req_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_s1 <= n_s1;
        end
        if (s1_adv) begin
            r_out.ok             <= r_s1.ok;
            r_out.out_x          <= r_s1.read_hit ? mem_rp.x : '0;
            r_out.out_y          <= r_s1.read_hit ? mem_rp.y : '0;
            r_out.at_end         <= r_s1.at_end;
            r_out.expired_flag   <= r_s1.expired;
            r_out.restarted_flag <= r_s1.restarted;
        end
    end

    a_wr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr <= r_size)
        else $error("write index beyond slots in use");

    a_empty_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr >= r_size) == (r_old >= r_size))
        else $error("oldest and write index disagree on empty");

    a_s1_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_fire |=> r_s1_valid)
        else $error("accepted request not held");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.payload.ok) |->
            (o_rsp.payload.out_x == '0 && o_rsp.payload.out_y == '0))
        else $error("point data on a failed request");

endmodule

### hw/rtl/orbr_point_mem.sv
module orbr_point_mem #(
    parameter  int DEPTH = 4096,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic            i_clk,
    input  logic            i_wr_en,
    input  logic [AW-1:0]   i_wr_addr,
    input  orbr_pkg::t_point i_wr_point,
    input  logic            i_rd_en,
    input  logic [AW-1:0]   i_rd_addr,
    output orbr_pkg::t_point o_rd_point
);

    orbr_pkg::t_point r_mem [DEPTH];
    orbr_pkg::t_point r_rd_point;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_point;
        end
        if (i_rd_en) begin
            r_rd_point <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_point = r_rd_point;

endmodule

### verif/overwrite_ring_buffer_with_readers_tb.sv
`timescale 1ns / 100ps

module overwrite_ring_buffer_with_readers_tb;

    localparam int SLOT_MAX    = 4096;
    localparam int NUM_READERS = 8;
    localparam int LONG_HOLD   = 200;

    logic i_clk;
    logic i_rst_n;

    orbr_chan_if #(.T(orbr_pkg::t_req))  req_if ();
    orbr_chan_if #(.T(orbr_pkg::t_rsp))  rsp_if ();
    orbr_chan_if #(.T(orbr_pkg::t_size)) cfg_if ();

    overwrite_ring_buffer_with_readers u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    // point ring and reader cursors as the block should hold them
    logic [63:0]        points [SLOT_MAX];
    int                 slots;
    int                 oldest_slot;
    int                 wr_slot;
    logic signed [31:0] last_x;
    int                 cursor    [NUM_READERS];
    bit                 restarted [NUM_READERS];
    bit                 expired   [NUM_READERS];
    bit                 at_end    [NUM_READERS];

    orbr_pkg::t_req req_backlog [$];
    orbr_pkg::t_rsp rsp_due     [$];
    orbr_pkg::t_rsp due_head;

    int                 errors;
    int                 tx_idle_pct;
    int                 rx_idle_pct;
    int                 stall_requests;
    int                 stalls_served;
    int                 hold_left;
    logic signed [31:0] stream_x;

    function automatic int next_slot(input int i);
        return (i + 1 >= slots) ? 0 : i + 1;
    endfunction

    function automatic void empty_ring();
        oldest_slot = slots;
        wr_slot     = slots;
        for (int r = 0; r < NUM_READERS; r++) begin
            restarted[r] = 1'b1;
            cursor[r]    = slots;
        end
    endfunction

    function automatic void power_on_state();
        foreach (points[i]) points[i] = '0;
        slots       = orbr_pkg::SIZE_AT_RESET;
        oldest_slot = slots;
        wr_slot     = slots;
        last_x      = '0;
        for (int r = 0; r < NUM_READERS; r++) begin
            cursor[r]    = slots;
            restarted[r] = 1'b0;
            expired[r]   = 1'b0;
            at_end[r]    = 1'b1;
        end
    endfunction

    function automatic void apply_slots(input int value);
        int n;
        n = value & 32'h1FFF;
        if (n == 0)
            n = 1;
        if (n > SLOT_MAX)
            n = SLOT_MAX;
        slots = n;
        empty_ring();
    endfunction

    function automatic orbr_pkg::t_rsp serve_request(input orbr_pkg::t_req rq);
        orbr_pkg::t_rsp     res;
        int                 rd;
        int                 lo;
        int                 hi;
        int                 pos;
        int                 off;
        bit                 was_empty;
        logic signed [31:0] xin;
        res       = '0;
        rd        = rq.reader;
        xin       = rq.in_x;
        off       = int'($signed(rq.offset));
        was_empty = (wr_slot >= slots);
        case (rq.kind)
            orbr_pkg::KIND_APPEND: begin
                if (rq.x_invalid || (!was_empty && last_x >= xin))
                    empty_ring();
                res.ok = 1'b1;
                if (!rq.x_invalid) begin
                    if (wr_slot >= slots) begin
                        oldest_slot = 0;
                        wr_slot     = 0;
                    end
                    points[wr_slot] = {xin, rq.in_y};
                    last_x          = xin;
                    wr_slot         = next_slot(wr_slot);
                    if (wr_slot == oldest_slot)
                        oldest_slot = next_slot(oldest_slot);
                    for (int r = 0; r < NUM_READERS; r++) begin
                        at_end[r] = 1'b0;
                        if (cursor[r] == wr_slot) begin
                            expired[r] = 1'b1;
                            cursor[r]  = oldest_slot;
                        end else if (cursor[r] >= slots) begin
                            cursor[r] = oldest_slot;
                        end
                    end
                end
            end
            orbr_pkg::KIND_REWIND: begin
                if (was_empty) begin
                    cursor[rd] = slots;
                    at_end[rd] = 1'b1;
                end else begin
                    cursor[rd] = oldest_slot;
                    at_end[rd] = 1'b0;
                    res.ok     = 1'b1;
                end
                restarted[rd] = 1'b0;
                expired[rd]   = 1'b0;
            end
            orbr_pkg::KIND_READ: begin
                if (!was_empty && cursor[rd] != wr_slot && cursor[rd] < slots) begin
                    {res.out_x, res.out_y} = points[cursor[rd]];
                    cursor[rd] = next_slot(cursor[rd]);
                    if (cursor[rd] == wr_slot)
                        at_end[rd] = 1'b1;
                    res.ok = 1'b1;
                end
            end
            orbr_pkg::KIND_MOVE: begin
                if (was_empty) begin
                    at_end[rd] = 1'b1;
                end else begin
                    lo  = oldest_slot;
                    hi  = wr_slot;
                    pos = cursor[rd];
                    if (hi < lo) begin
                        hi += slots;
                        if (pos < lo)
                            pos += slots;
                    end
                    if (off >= hi - pos) begin
                        pos        = hi;
                        at_end[rd] = 1'b1;
                    end else if (off <= lo - pos) begin
                        pos        = lo;
                        at_end[rd] = 1'b0;
                    end else begin
                        pos       += off;
                        at_end[rd] = 1'b0;
                    end
                    if (pos >= slots)
                        pos -= slots;
                    cursor[rd] = pos;
                end
            end
        endcase
        res.at_end         = at_end[rd];
        res.expired_flag   = expired[rd];
        res.restarted_flag = restarted[rd];
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %h, actual %h", name, want, got);
            errors++;
        end
    endtask

    task automatic queue_request(input orbr_pkg::t_kind k, input logic [31:0] x,
                                 input logic [31:0] y, input logic bad, input int rd,
                                 input int off);
        orbr_pkg::t_req rq;
        rq.kind      = k;
        rq.in_x      = x;
        rq.in_y      = y;
        rq.x_invalid = bad;
        rq.reader    = rd[2:0];
        rq.offset    = off[15:0];
        req_backlog.push_back(rq);
    endtask

    task automatic add_random_items(input int count);
        int                 pick;
        int                 off;
        longint             nx;
        logic signed [31:0] x;
        logic               bad;
        orbr_pkg::t_kind    k;
        repeat (count) begin
            pick = $urandom_range(99);
            bad  = 1'b0;
            x    = $urandom;
            off  = $urandom;
            if (pick < 45) begin
                k    = orbr_pkg::KIND_APPEND;
                pick = $urandom_range(99);
                if (pick < 85) begin
                    nx = longint'(stream_x)
                         + ($urandom_range(9) == 0 ? $urandom_range(1, 1 << 28)
                                                   : $urandom_range(1, 65536));
                    if (nx > 64'sd2147483647)
                        nx = -64'sd2147483648 + $urandom_range(0, 1 << 20);
                    x = nx[31:0];
                end else if (pick < 90) begin
                    bad = 1'b1;
                end else if (pick < 95) begin
                    x = stream_x;
                end
                if (!bad)
                    stream_x = x;
            end else if (pick < 75) begin
                k = orbr_pkg::KIND_READ;
            end else if (pick < 85) begin
                k = orbr_pkg::KIND_REWIND;
            end else begin
                k    = orbr_pkg::KIND_MOVE;
                pick = $urandom_range(99);
                if (pick < 60)
                    off = int'($urandom_range(16)) - 8;
                else if (pick < 75)
                    off = ($urandom_range(1) != 0) ? 32767 : -32768;
            end
            queue_request(k, x, $urandom, bad, $urandom_range(NUM_READERS - 1), off);
        end
    endtask

    task automatic wait_idle();
        while (req_backlog.size() != 0 || req_if.valid || rsp_due.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_slots(input int value);
        @(posedge i_clk);
        cfg_if.valid   <= 1'b1;
        cfg_if.payload <= orbr_pkg::t_size'(value);
        do @(posedge i_clk); while (!cfg_if.ready);
        apply_slots(value);
        cfg_if.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic random_phase(input int size_value, input int count);
        wait_idle();
        write_slots(size_value);
        add_random_items(count);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // hold each request until taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready)
                rsp_due.push_back(serve_request(req_if.payload));
            if (!req_if.valid || req_if.ready) begin
                if (req_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    req_if.valid   <= 1'b1;
                    req_if.payload <= req_backlog.pop_front();
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready  <= 1'b0;
            hold_left     <= 0;
            stalls_served <= 0;
        end else if (stalls_served != stall_requests) begin
            stalls_served <= stall_requests;
            hold_left     <= LONG_HOLD;
            rsp_if.ready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (rsp_due.size() == 0) begin
                $error("response with no request outstanding");
                errors++;
            end else begin
                due_head = rsp_due.pop_front();
                check_field("ok", due_head.ok, rsp_if.payload.ok);
                check_field("out_x", due_head.out_x, rsp_if.payload.out_x);
                check_field("out_y", due_head.out_y, rsp_if.payload.out_y);
                check_field("at_end", due_head.at_end, rsp_if.payload.at_end);
                check_field("expired_flag", due_head.expired_flag,
                            rsp_if.payload.expired_flag);
                check_field("restarted_flag", due_head.restarted_flag,
                            rsp_if.payload.restarted_flag);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("[overwrite_ring_buffer_with_readers] ERROR");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        rsp_if.ready   = 1'b0;
        cfg_if.valid   = 1'b0;
        cfg_if.payload = '0;
        errors         = 0;
        stall_requests = 0;
        stream_x       = '0;
        tx_idle_pct    = 17;
        rx_idle_pct    = 71;
        power_on_state();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        queue_request(orbr_pkg::KIND_READ,   0, 0, 1'b0, 0, 0);
        queue_request(orbr_pkg::KIND_REWIND, 0, 0, 1'b0, 1, 0);
        queue_request(orbr_pkg::KIND_MOVE,   0, 0, 1'b0, 2, 5);
        queue_request(orbr_pkg::KIND_APPEND, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 0, 0);
        queue_request(orbr_pkg::KIND_APPEND, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1, 0);
        queue_request(orbr_pkg::KIND_REWIND, 0, 0, 1'b0, 0, 0);
        queue_request(orbr_pkg::KIND_READ,   0, 0, 1'b0, 0, 0);
        queue_request(orbr_pkg::KIND_MOVE,   0, 0, 1'b0, 0, 32767);
        queue_request(orbr_pkg::KIND_MOVE,   0, 0, 1'b0, 0, -32768);
        queue_request(orbr_pkg::KIND_APPEND, 32'h7FFF_FFFF, 32'h1234_5678, 1'b0, 0, 0);
        queue_request(orbr_pkg::KIND_READ,   0, 0, 1'b0, 0, 0);
        queue_request(orbr_pkg::KIND_APPEND, 0, 0, 1'b1, 0, 0);
        queue_request(orbr_pkg::KIND_READ,   0, 0, 1'b0, 0, 0);
        wait_idle();
        write_slots(0);
        queue_request(orbr_pkg::KIND_APPEND, 1, 11, 1'b0, 3, 0);
        queue_request(orbr_pkg::KIND_APPEND, 2, 22, 1'b0, 3, 0);
        queue_request(orbr_pkg::KIND_READ,   0, 0, 1'b0, 3, 0);
        queue_request(orbr_pkg::KIND_REWIND, 0, 0, 1'b0, 3, 0);
        queue_request(orbr_pkg::KIND_MOVE,   0, 0, 1'b0, 3, -32768);
        wait_idle();
        write_slots(8191);
        queue_request(orbr_pkg::KIND_APPEND, 5, 55, 1'b0, 5, 0);
        queue_request(orbr_pkg::KIND_READ,   0, 0, 1'b0, 5, 0);
        wait_idle();
        write_slots(2);
        queue_request(orbr_pkg::KIND_APPEND, 10, 100, 1'b0, 6, 0);
        queue_request(orbr_pkg::KIND_READ,   0, 0, 1'b0, 6, 0);
        queue_request(orbr_pkg::KIND_APPEND, 20, 200, 1'b0, 6, 0);
        queue_request(orbr_pkg::KIND_APPEND, 30, 300, 1'b0, 6, 0);
        queue_request(orbr_pkg::KIND_READ,   0, 0, 1'b0, 6, 0);
        queue_request(orbr_pkg::KIND_MOVE,   0, 0, 1'b0, 7, 0);
        queue_request(orbr_pkg::KIND_READ,   0, 0, 1'b0, 7, 0);

        random_phase(4, 300);
        random_phase(3000, 150);
        random_phase(7, 200);

        wait_idle();
        tx_idle_pct = 71;
        rx_idle_pct = 17;
        random_phase(16, 300);
        random_phase(4096, 100);
        random_phase(2, 200);

        wait_idle();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_phase(5, 150);
        // drop ready for a long stretch while requests keep coming
        stall_requests++;
        add_random_items(150);
        wait_idle();
        add_random_items(50);
        random_phase(1, 100);
        random_phase($urandom_range(1, 64), 250);

        wait_idle();
        repeat (4) @(negedge i_clk);
        if (errors == 0)
            $display("[overwrite_ring_buffer_with_readers] OK");
        else
            $display("[overwrite_ring_buffer_with_readers] ERROR");
        $finish;
    end

endmodule
